[rtl/rsi_pkg.sv]
// Shared constants, command type and codes for the RSI block.
`default_nettype none
package rsi_pkg;

	localparam int PRICE_BITS    = 32;
	localparam int FRACTION_BITS = 16;
	localparam int MAX_PERIOD    = 256;
	localparam int PERIOD_BITS   = 9;
	localparam int RSI_BITS      = 14;

	localparam int COUNT_BITS = $clog2(MAX_PERIOD + 1);
	localparam int ACC_BITS   = PRICE_BITS + FRACTION_BITS;
	// warm-up sums never exceed MAX_PERIOD full-scale differences
	localparam int SUM_BITS   = PRICE_BITS + $clog2(MAX_PERIOD);
	localparam int DIVP_STEPS = (SUM_BITS + FRACTION_BITS + 1) / 2;
	localparam int DIVP_BITS  = 2 * DIVP_STEPS;
	localparam int TOTAL_BITS = ACC_BITS + 1;
	localparam int PROD_BITS  = ACC_BITS + RSI_BITS;
	localparam int STEP_BITS  = $clog2((DIVP_STEPS > RSI_BITS) ? DIVP_STEPS : RSI_BITS);

	localparam int S_TDATA_BITS = ((PRICE_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = ((RSI_BITS + 7) / 8) * 8;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_FILL_BITS = $clog2(FIFO_DEPTH + 1);

	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);
	localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = PERIOD_BITS'(MAX_PERIOD);
	localparam logic [RSI_BITS-1:0] FULL_SCALE = RSI_BITS'(10000);

	// command kinds
	localparam logic [1:0] KIND_ACCUM  = 2'd0;  // add to warm-up sums
	localparam logic [1:0] KIND_FIRST  = 2'd1;  // add, then first average and result
	localparam logic [1:0] KIND_SMOOTH = 2'd2;  // Wilder smoothing and result

	typedef struct packed {
		logic [1:0]            kind;
		logic                  clr;      // sums start from zero
		logic                  is_loss;  // mag is a loss, else a gain
		logic [PRICE_BITS-1:0] mag;
	} rsi_cmd_t;

endpackage
`default_nettype wire

[rtl/rsi_cmd_fifo.sv]
// Short command queue between the RSI front and back.
`default_nettype none
module rsi_cmd_fifo import rsi_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire rsi_cmd_t push_cmd,
	output logic          full,
	input  wire logic     pop,
	output rsi_cmd_t      head_cmd,
	output logic          empty
);

	rsi_cmd_t                  entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0]  wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0]  rd_ptr_q;
	logic [FIFO_FILL_BITS-1:0] fill_q;
	logic                      do_push;
	logic                      do_pop;

	assign full     = (fill_q == FIFO_FILL_BITS'(FIFO_DEPTH));
	assign empty    = (fill_q == '0);
	assign head_cmd = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 :
					wr_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 :
					rd_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FIFO_FILL_BITS'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FIFO_FILL_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

[rtl/rsi_front.sv]
// RSI front: takes prices, forms differences and classifies each one.
`default_nettype none
module rsi_front import rsi_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [S_TDATA_BITS-1:0] s_tdata,
	input  wire logic                    s_tuser,
	input  wire logic                    cfg_we,
	input  wire logic [PERIOD_BITS-1:0]  period_act,
	input  wire logic                    fifo_full,
	output logic                         push,
	output rsi_cmd_t                     push_cmd
);

	logic [PRICE_BITS-1:0] prev_q;
	logic                  seen_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [PRICE_BITS-1:0] price;
	logic                  accept;
	logic                  new_series;
	logic                  rising;
	logic                  warm;

	assign price      = s_tdata[PRICE_BITS-1:0];
	assign s_tready   = !fifo_full;
	assign accept     = s_tvalid && s_tready;
	assign new_series = s_tuser || !seen_q;
	assign rising     = (price >= prev_q);
	assign warm       = (count_q < COUNT_BITS'(period_act));
	assign push       = accept && !new_series;

	always_comb begin
		push_cmd.mag     = rising ? (price - prev_q) : (prev_q - price);
		push_cmd.is_loss = !rising;
		push_cmd.clr     = (count_q == '0);
		if (!warm) begin
			push_cmd.kind = KIND_SMOOTH;
		end else if ((count_q + COUNT_BITS'(1)) == COUNT_BITS'(period_act)) begin
			push_cmd.kind = KIND_FIRST;
		end else begin
			push_cmd.kind = KIND_ACCUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			seen_q  <= 1'b0;
			count_q <= '0;
		end else if (cfg_we) begin
			seen_q  <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			prev_q <= price;
			if (new_series) begin
				seen_q  <= 1'b1;
				count_q <= '0;
			end else if (warm) begin
				count_q <= count_q + COUNT_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

[rtl/rsi_back.sv]
// RSI back: warm-up sums, averaging by period, ratio divide and output register.
`default_nettype none
module rsi_back import rsi_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [PERIOD_BITS-1:0]  period_act,
	input  wire logic                    fifo_empty,
	input  wire rsi_cmd_t                head_cmd,
	output logic                         pop,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [M_TDATA_BITS-1:0]      m_tdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIVP = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIVR = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]           state_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 m_tvalid_q;

	// lane 0 = gain, lane 1 = loss
	logic [ACC_BITS-1:0]    acc_q [2];
	logic [PERIOD_BITS-1:0] rem_q [2];
	logic [DIVP_BITS-1:0]   sh_q [2];
	logic                   up_q [2];
	logic                   avg_q;
	logic [TOTAL_BITS-1:0]  rrem_q;
	logic [RSI_BITS-1:0]    rlow_q;
	logic [TOTAL_BITS-1:0]  total_q;
	logic                   zero_q;
	logic [RSI_BITS-1:0]    res_q;

	logic [ACC_BITS-1:0]    base [2];
	logic [ACC_BITS-1:0]    sum [2];
	logic [ACC_BITS-1:0]    vshift [2];
	logic                   v_up [2];
	logic [TOTAL_BITS-1:0]  d_sel [2];
	logic [PERIOD_BITS-1:0] rem_nx [2];
	logic [DIVP_BITS-1:0]   sh_nx [2];
	logic [ACC_BITS-1:0]    acc_nx [2];
	logic [PROD_BITS-1:0]   prod;
	logic [TOTAL_BITS:0]    rr_r;
	logic [TOTAL_BITS-1:0]  rrem_nx;
	logic                   rq_bit;
	logic                   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign pop      = (state_q == ST_IDLE) && !fifo_empty;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_BITS'(res_q);
	assign prod     = PROD_BITS'(acc_q[0]) * PROD_BITS'(FULL_SCALE);

	// command operands, warm-up sums and smoothing differences
	always_comb begin
		logic [PRICE_BITS-1:0] val;
		for (int i = 0; i < 2; i++) begin
			val       = (head_cmd.is_loss == (i == 1)) ? head_cmd.mag : '0;
			base[i]   = head_cmd.clr ? '0 : acc_q[i];
			sum[i]    = base[i] + ACC_BITS'(val);
			vshift[i] = {val, {FRACTION_BITS{1'b0}}};
			v_up[i]   = (vshift[i] >= base[i]);
			// falling side subtracts ceil((old - v) / p), so the result rounds down
			d_sel[i]  = v_up[i] ?
				(TOTAL_BITS'(vshift[i]) - TOTAL_BITS'(base[i])) :
				(TOTAL_BITS'(base[i]) + TOTAL_BITS'(period_act - PERIOD_BITS'(1))
					- TOTAL_BITS'(vshift[i]));
		end
	end

	// two restoring steps per cycle for the divide by period
	always_comb begin
		logic [PERIOD_BITS:0]   r;
		logic [DIVP_BITS-1:0]   s;
		logic [ACC_BITS-1:0]    q;
		for (int i = 0; i < 2; i++) begin
			r = '0;
			s = sh_q[i];
			rem_nx[i] = rem_q[i];
			for (int b = 0; b < 2; b++) begin
				r = {rem_nx[i], s[DIVP_BITS-1]};
				s = {s[DIVP_BITS-2:0], 1'b0};
				if (r >= {1'b0, period_act}) begin
					r = r - {1'b0, period_act};
					s[0] = 1'b1;
				end
				rem_nx[i] = r[PERIOD_BITS-1:0];
			end
			sh_nx[i] = s;
			q = sh_q[i][ACC_BITS-1:0];
			if (avg_q) begin
				acc_nx[i] = q;
			end else if (up_q[i]) begin
				acc_nx[i] = acc_q[i] + q;
			end else begin
				acc_nx[i] = acc_q[i] - q;
			end
		end
	end

	// one restoring step per cycle for 10000*G/(G+L)
	always_comb begin
		rr_r = {rrem_q, rlow_q[RSI_BITS-1]};
		rq_bit = (rr_r >= {1'b0, total_q});
		rrem_nx = rq_bit ? TOTAL_BITS'(rr_r - {1'b0, total_q}) : rr_r[TOTAL_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a new result loads as the old one leaves
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (pop && head_cmd.kind != KIND_ACCUM) begin
						state_q <= ST_DIVP;
					end
				end
				ST_DIVP: begin
					step_q <= step_q + STEP_BITS'(1);
					if (step_q == STEP_BITS'(DIVP_STEPS - 1)) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIVR;
				end
				ST_DIVR: begin
					step_q <= step_q + STEP_BITS'(1);
					if (step_q == STEP_BITS'(RSI_BITS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					for (int i = 0; i < 2; i++) begin
						rem_q[i] <= '0;
						up_q[i]  <= v_up[i];
						case (head_cmd.kind)
							KIND_ACCUM: acc_q[i] <= sum[i];
							KIND_FIRST: sh_q[i] <= DIVP_BITS'({sum[i][SUM_BITS-1:0],
								{FRACTION_BITS{1'b0}}});
							KIND_SMOOTH: sh_q[i] <= DIVP_BITS'(d_sel[i]);
							default: ;
						endcase
					end
					avg_q <= (head_cmd.kind == KIND_FIRST);
				end
			end
			ST_DIVP: begin
				for (int i = 0; i < 2; i++) begin
					rem_q[i] <= rem_nx[i];
					sh_q[i]  <= sh_nx[i];
				end
			end
			ST_UPD: begin
				for (int i = 0; i < 2; i++) begin
					acc_q[i] <= acc_nx[i];
				end
			end
			ST_MUL: begin
				// quotient is at most 10000, so the upper product bits stay below the total
				rrem_q  <= TOTAL_BITS'(prod[PROD_BITS-1:RSI_BITS]);
				rlow_q  <= prod[RSI_BITS-1:0];
				total_q <= TOTAL_BITS'(acc_q[0]) + TOTAL_BITS'(acc_q[1]);
				zero_q  <= (acc_q[0] == '0) && (acc_q[1] == '0);
			end
			ST_DIVR: begin
				rrem_q <= rrem_nx;
				rlow_q <= {rlow_q[RSI_BITS-2:0], rq_bit};
			end
			ST_OUT: begin
				if (out_free) begin
					res_q <= zero_q ? FULL_SCALE : rlow_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[rtl/relative_strength_index_top.sv]
// Top level of the Wilder relative strength index block.
`default_nettype none
// Wilder RSI over a stream of prices. Each request carries one unsigned
// price in s_tdata and a restart flag in s_tuser; the first price of a series
// (after reset, a restart or a period write) only primes the previous price.
// Differences are split into gains and losses, summed over the first
// `period` differences, averaged with 16 fraction bits, then Wilder
// smoothed. From the period-th difference on, every price yields one result:
// floor(10000*G/(G+L)) on m_tdata, or 10000 when both averages are zero.
// The front takes one price per cycle while its two-entry command queue has
// room. The back adds a warm-up difference to the sums as it leaves the queue;
// a difference that yields a result passes 28 radix-4 steps of the divide by
// period (gain and loss lanes side by side), one update, one multiply by
// 10000, 14 steps of the ratio divide and the output register. The back takes
// no new difference until the result is in the output register, which waits
// on m_tready. period (cfg_wdata) resets to 14; 0 acts as 1 and values above
// 256 act as 256. Write it only while the block is idle.
module relative_strength_index_top import rsi_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [S_TDATA_BITS-1:0] s_tdata,   // [31:0] price
	input  wire logic                    s_tuser,   // [0] restart
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [M_TDATA_BITS-1:0]      m_tdata,   // [13:0] rsi_hundredths, [15:14] zero
	input  wire logic                    cfg_we,
	input  wire logic [PERIOD_BITS-1:0]  cfg_wdata   // period
);

	logic [PERIOD_BITS-1:0] period_q;
	logic [PERIOD_BITS-1:0] period_act;
	logic                   fifo_full;
	logic                   fifo_empty;
	logic                   push;
	logic                   pop;
	rsi_cmd_t               push_cmd;
	rsi_cmd_t               head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// clamp the programmed period into 1..MAX_PERIOD
	always_comb begin
		if (period_q == '0) begin
			period_act = PERIOD_BITS'(1);
		end else if (period_q > PERIOD_MAX) begin
			period_act = PERIOD_MAX;
		end else begin
			period_act = period_q;
		end
	end

	// front: previous price, series state, difference classification
	rsi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg_we     (cfg_we),
		.period_act (period_act),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	rsi_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (fifo_empty)
	);

	// back: averages, smoothing, ratio and output register
	rsi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.period_act (period_act),
		.fifo_empty (fifo_empty),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
`default_nettype wire

[dv/relative_strength_index_top_test.sv]
// Self-checking testbench for the Wilder RSI block: directed rows, then random price series.
`timescale 1ns / 1ps

module relative_strength_index_top_test;
	import rsi_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int RESET_TICKS = 11;
	localparam int SETTLE      = 100;   // worst case one result plus slack
	localparam int HOLD_CYCLES = 600;   // long receiver hold-off
	localparam int STALL_LIMIT = 4000;  // cycles with no request moving on either side
	localparam int PHASES      = 8;

	localparam logic [63:0] ACC_MASK  = (64'd1 << ACC_BITS) - 64'd1;
	localparam logic [63:0] RATIO_CAP = 64'd1 << (ACC_BITS + 1);

	// one directed row: optional period write first, then one price request
	typedef struct packed {
		logic                   wr;
		logic [PERIOD_BITS-1:0] wdata;
		logic [PRICE_BITS-1:0]  price;
		logic                   restart;
		logic                   pinned;   // rsi below is the known answer
		logic [RSI_BITS-1:0]    rsi;
	} steer_row_t;

	localparam int STEER_ROWS = 24;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata;
	logic                    s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [M_TDATA_BITS-1:0] m_tdata;
	logic                    cfg_we;
	logic [PERIOD_BITS-1:0]  cfg_wdata;

	relative_strength_index_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predictor state
	logic [PERIOD_BITS-1:0] window_reg;
	logic [PRICE_BITS-1:0]  last_close;
	bit                     close_seen;
	int unsigned            diff_cnt;
	logic [63:0]            gain_avg;
	logic [63:0]            loss_avg;

	logic [RSI_BITS-1:0] rsi_expected[$];
	int                  mismatches = 0;
	int                  burst_left = 0;
	int                  quiet_cycles = 0;
	bit                  hold_req = 1'b0;
	logic [PRICE_BITS-1:0] walk;

	steer_row_t steer_rows [STEER_ROWS] = '{
		// reset period 14: flat prices, both averages end at zero
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},  // first price only primes
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'd7, 1'b0, 1'b1, FULL_SCALE},  // 14th difference
		// period 1: each difference decides alone
		'{1'b1, 9'd1, 32'd0, 1'b1, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, FULL_SCALE},
		'{1'b0, 9'd0, 32'd0, 1'b0, 1'b1, 14'd0},
		'{1'b0, 9'd0, 32'd0, 1'b0, 1'b1, FULL_SCALE},
		// period 0 acts as 1; the write itself ends the series
		'{1'b1, 9'd0, 32'd100, 1'b0, 1'b0, 14'd0},
		'{1'b0, 9'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, FULL_SCALE},
		'{1'b0, 9'd0, 32'd0, 1'b0, 1'b1, 14'd0},
		'{1'b0, 9'd0, 32'd50, 1'b1, 1'b0, 14'd0},     // restart mid series
		'{1'b0, 9'd0, 32'd60, 1'b0, 1'b1, FULL_SCALE}
	};

	function automatic void clear_series();
		close_seen = 1'b0;
		diff_cnt   = 0;
		gain_avg   = '0;
		loss_avg   = '0;
	endfunction

	// floor(sum * 2^FRACTION_BITS / p)
	function automatic logic [63:0] first_avg(input logic [63:0] sum, input int unsigned p);
		logic [63:0] q;
		logic [63:0] r;
		q = sum / p;
		r = sum % p;
		return ((q << FRACTION_BITS) + ((r << FRACTION_BITS) / p)) & ACC_MASK;
	endfunction

	// floor((old*(p-1) + v) / p)
	function automatic logic [63:0] wilder(input logic [63:0] old, input logic [63:0] v,
			input int unsigned p);
		logic [63:0] d;
		if (v >= old)
			return (old + (v - old) / p) & ACC_MASK;
		d = old - v;
		return (old - (d + p - 1) / p) & ACC_MASK;
	endfunction

	function automatic logic [RSI_BITS-1:0] strength(input logic [63:0] g, input logic [63:0] l);
		logic [63:0] total;
		while (g + l >= RATIO_CAP) begin
			g = g >> 1;
			l = l >> 1;
		end
		total = g + l;
		if (total == 0)
			return FULL_SCALE;
		return RSI_BITS'((g * 64'(FULL_SCALE)) / total);
	endfunction

	// advance the predictor by one price; returns 1 when a result is due
	function automatic bit rsi_advance(input logic [PRICE_BITS-1:0] price, input bit restart,
			output logic [RSI_BITS-1:0] rsi);
		int unsigned p;
		logic [63:0] gain;
		logic [63:0] loss;
		p    = (window_reg == 0) ? 1 : (window_reg > PERIOD_MAX) ? MAX_PERIOD : window_reg;
		gain = '0;
		loss = '0;
		rsi  = '0;
		if (restart || !close_seen) begin
			clear_series();
			last_close = price;
			close_seen = 1'b1;
			return 1'b0;
		end
		if (price >= last_close)
			gain = 64'(price) - 64'(last_close);
		else
			loss = 64'(last_close) - 64'(price);
		last_close = price;
		if (diff_cnt < p) begin
			gain_avg = (gain_avg + gain) & ACC_MASK;
			loss_avg = (loss_avg + loss) & ACC_MASK;
			diff_cnt++;
			if (diff_cnt < p)
				return 1'b0;
			gain_avg = first_avg(gain_avg, p);
			loss_avg = first_avg(loss_avg, p);
		end else begin
			gain_avg = wilder(gain_avg, gain << FRACTION_BITS, p);
			loss_avg = wilder(loss_avg, loss << FRACTION_BITS, p);
		end
		rsi = strength(gain_avg, loss_avg);
		return 1'b1;
	endfunction

	// random walk with jumps to the rails and to random prices
	function automatic logic [PRICE_BITS-1:0] next_close();
		case ($urandom_range(0, 11))
			0: walk = '0;
			1: walk = '1;
			2: walk = $urandom;
			3: ;  // flat: zero difference
			4: walk = walk + $urandom_range(0, 1 << 20);
			5: walk = walk - $urandom_range(0, 1 << 20);
			6, 7, 8: walk = walk + $urandom_range(0, 2000);
			default: walk = walk - $urandom_range(0, 2000);
		endcase
		return walk;
	endfunction

	// offer one price request in bursts; on acceptance record what it should yield
	task automatic send_price(input logic [PRICE_BITS-1:0] price, input bit restart,
			input bit pinned, input logic [RSI_BITS-1:0] pinned_rsi);
		int gap;
		bit yields;
		logic [RSI_BITS-1:0] rsi;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= price;
		s_tuser  <= restart;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		yields = rsi_advance(price, restart, rsi);
		if (pinned)
			rsi_expected.push_back(pinned_rsi);
		else if (yields)
			rsi_expected.push_back(rsi);
	endtask

	// quiesce: stop offering, collect every result, then let warm-up work finish
	task automatic drain_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (rsi_expected.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		window_reg = value;
		clear_series();
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (rsi_expected.size() == 0) begin
				$error("rsi_hundredths: no result expected, actual %0d", m_tdata[RSI_BITS-1:0]);
				mismatches++;
			end else begin
				if (m_tdata[RSI_BITS-1:0] !== rsi_expected[0]) begin
					$error("rsi_hundredths: expected %0d, actual %0d",
						rsi_expected[0], m_tdata[RSI_BITS-1:0]);
					mismatches++;
				end
				void'(rsi_expected.pop_front());
			end
		end
	end

	// watchdog: no request moving on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("relative_strength_index_top_test: errors");
			$finish;
		end
	end

	// receiver: rotating stall patterns, plus one long hold-off on request
	initial begin : receiver
		logic [31:0] tick;
		bit held;
		tick = '0;
		held = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req && !held) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end else begin
				case (tick[7:6])
					2'd0: m_tready <= 1'b1;
					2'd1: m_tready <= 1'($urandom_range(0, 1));
					2'd2: m_tready <= (tick[1:0] == 2'd0);
					default: m_tready <= (tick % 5 != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		int phase_period [PHASES] = '{2, 256, 511, 14, 1, 3, -1, -1};
		int phase_items  [PHASES] = '{30, 262, 30, 30, 30, 30, 30, 30};
		int ph;
		int k;
		bit restart;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		walk      = $urandom;

		window_reg = PERIOD_RESET;
		last_close = '0;
		clear_series();

		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (k = 0; k < STEER_ROWS; k++) begin
			if (steer_rows[k].wr) begin
				drain_idle();
				write_period(steer_rows[k].wdata);
			end
			send_price(steer_rows[k].price, steer_rows[k].restart,
				steer_rows[k].pinned, steer_rows[k].rsi);
		end

		// random series, one period setting per phase
		for (ph = 0; ph < PHASES; ph++) begin
			drain_idle();
			if (phase_period[ph] < 0)
				write_period(PERIOD_BITS'($urandom_range(1, 20)));
			else
				write_period(PERIOD_BITS'(phase_period[ph]));
			// period 1 yields a result per price: best phase to back the block up
			if (phase_period[ph] == 1)
				hold_req = 1'b1;
			for (k = 0; k < phase_items[ph]; k++) begin
				// rare restarts break series; none in the long warm-up phase
				restart = (k == 0) ? 1'($urandom_range(0, 1)) :
					(phase_items[ph] < 100 && $urandom_range(0, 39) == 0);
				send_price(next_close(), restart, 1'b0, '0);
			end
		end

		drain_idle();
		if (rsi_expected.size() != 0)
			$error("rsi_hundredths: %0d results never arrived", rsi_expected.size());
		if (mismatches == 0 && rsi_expected.size() == 0)
			$display("relative_strength_index_top_test: clean");
		else
			$display("relative_strength_index_top_test: errors");
		$finish;
	end

endmodule
